>>> src/stepper_half_step_position_driver_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the half-step position driver
// Shared property forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef STEPPER_HALF_STEP_POSITION_DRIVER_CORE_MACROS_SVH
`define STEPPER_HALF_STEP_POSITION_DRIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SHDRV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SHDRV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/shdrv_pkg.sv
// ----------------------------------------------------------------------------
// shdrv_pkg
// Types, operation codes and the half-step coil table.
// ----------------------------------------------------------------------------
package shdrv_pkg;

  localparam int unsigned OpWidth     = 2;
  localparam int unsigned FieldWidth  = 32;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CoilWidth   = 4;
  localparam int unsigned PeriodReset = 10;

  typedef enum logic [OpWidth-1:0] {
    OP_TICK      = 2'd0,
    OP_SET_TGT   = 2'd1,
    OP_STEP_CW   = 2'd2,
    OP_STEP_CCW  = 2'd3
  } op_e;

  // One result transaction.
  typedef struct packed {
    logic [CoilWidth-1:0]  coil_pattern;
    logic [FieldWidth-1:0] position;
    logic [FieldWidth-1:0] target;
    logic                  stepped;
  } result_t;

  // Half-step coil sequence, indexed by position modulo 8.
  function automatic logic [CoilWidth-1:0] half_step_coil(input logic [2:0] idx);
    logic [CoilWidth-1:0] coil;
    case (idx)
      3'd0:    coil = 4'b1000;
      3'd1:    coil = 4'b1100;
      3'd2:    coil = 4'b0100;
      3'd3:    coil = 4'b0110;
      3'd4:    coil = 4'b0010;
      3'd5:    coil = 4'b0011;
      3'd6:    coil = 4'b0001;
      3'd7:    coil = 4'b1001;
      default: coil = 4'b0000;
    endcase
    return coil;
  endfunction

endpackage

>>> src/stepper_half_step_position_driver_core.sv
// ----------------------------------------------------------------------------
// stepper_half_step_position_driver_core
// Half-step stepper sequencer that walks a position counter toward a target.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries op_i and target_step_i:
//   a 1 ms tick, a new target, or a manual clockwise / anticlockwise step.
//   Every input transaction produces exactly one output transaction on
//   out_valid_o / out_ready_i carrying coil_pattern_o, position_o, target_o
//   and stepped_o as they stand after that item.
//   Throughput: one transaction per cycle while in_ready_o is high; all
//   work is one short pass of logic from the state registers into the
//   result register (or the skid register while the head is stalled).
//   Stall: a two-entry output stage (result register plus skid register)
//   keeps in_ready_o high while one result waits; in_ready_o drops only
//   when both entries are full, and rises again as soon as one is taken.
//   Configuration: cfg_we_i writes step_period (ticks between automatic
//   steps, 0 acts as 1); write only while the block is idle.
//   Reset: position, target, tick wait and coils clear to zero (first tick
//   makes a step decision), step_period returns to 10, output stage empties.
// ----------------------------------------------------------------------------
module stepper_half_step_position_driver_core #(
  parameter int unsigned POSITION_WIDTH = 32,
  parameter int unsigned PERIOD_WIDTH   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write
  input  logic                                  cfg_we_i,
  input  logic [shdrv_pkg::CfgWidth-1:0]        cfg_wdata_i,
  // input transactions
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [shdrv_pkg::OpWidth-1:0]         op_i,
  input  logic signed [shdrv_pkg::FieldWidth-1:0] target_step_i,
  // output transactions
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [shdrv_pkg::CoilWidth-1:0]       coil_pattern_o,
  output logic signed [shdrv_pkg::FieldWidth-1:0] position_o,
  output logic signed [shdrv_pkg::FieldWidth-1:0] target_o,
  output logic                                  stepped_o
);

  // Motor state
  logic [POSITION_WIDTH-1:0]        pos_q, pos_d;
  logic [POSITION_WIDTH-1:0]        tgt_q, tgt_d;
  logic [PERIOD_WIDTH-1:0]          wait_q, wait_d;
  logic [shdrv_pkg::CoilWidth-1:0]  coil_q, coil_d;
  logic [PERIOD_WIDTH-1:0]          period_q;

  // Output stage: head register plus skid register
  shdrv_pkg::result_t res_new;
  shdrv_pkg::result_t out_q, out_d;
  shdrv_pkg::result_t skid_q, skid_d;
  logic               out_vld_q, out_vld_d;
  logic               skid_vld_q, skid_vld_d;

  logic push;
  logic pop;

  assign in_ready_o = ~skid_vld_q;
  assign push       = in_valid_i & in_ready_o;
  assign pop        = out_vld_q & out_ready_i;

  shdrv_step_unit #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .PERIOD_WIDTH   (PERIOD_WIDTH)
  ) u_step (
    .op_i          (shdrv_pkg::op_e'(op_i)),
    .target_step_i (target_step_i),
    .pos_i         (pos_q),
    .tgt_i         (tgt_q),
    .wait_i        (wait_q),
    .coil_i        (coil_q),
    .period_i      (period_q),
    .pos_o         (pos_d),
    .tgt_o         (tgt_d),
    .wait_o        (wait_d),
    .coil_o        (coil_d),
    .result_o      (res_new)
  );

  // State advances only on an accepted input transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      tgt_q  <= '0;
      wait_q <= '0;
      coil_q <= '0;
    end else if (push) begin
      pos_q  <= pos_d;
      tgt_q  <= tgt_d;
      wait_q <= wait_d;
      coil_q <= coil_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_WIDTH'(shdrv_pkg::PeriodReset);
    end else if (cfg_we_i) begin
      period_q <= PERIOD_WIDTH'(cfg_wdata_i);
    end
  end

  // Skid is only ever filled while the head is full and stalled, and a
  // push never coincides with a full skid, so ordering is kept.
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (!out_vld_q || pop) begin
      out_vld_d  = skid_vld_q | push;
      out_d      = skid_vld_q ? skid_q : res_new;
      skid_vld_d = 1'b0;
    end else if (push) begin
      skid_vld_d = 1'b1;
      skid_d     = res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_vld_q;
  assign coil_pattern_o = out_q.coil_pattern;
  assign position_o     = out_q.position;
  assign target_o       = out_q.target;
  assign stepped_o      = out_q.stepped;

endmodule

>>> src/shdrv_step_unit.sv
// ----------------------------------------------------------------------------
// shdrv_step_unit
// Next-state and result logic for one transaction (combinational).
// ----------------------------------------------------------------------------
module shdrv_step_unit #(
  parameter int unsigned POSITION_WIDTH = 32,
  parameter int unsigned PERIOD_WIDTH   = 16
) (
  input  shdrv_pkg::op_e                         op_i,
  input  logic [shdrv_pkg::FieldWidth-1:0]       target_step_i,
  input  logic [POSITION_WIDTH-1:0]              pos_i,
  input  logic [POSITION_WIDTH-1:0]              tgt_i,
  input  logic [PERIOD_WIDTH-1:0]                wait_i,
  input  logic [shdrv_pkg::CoilWidth-1:0]        coil_i,
  input  logic [PERIOD_WIDTH-1:0]                period_i,
  output logic [POSITION_WIDTH-1:0]              pos_o,
  output logic [POSITION_WIDTH-1:0]              tgt_o,
  output logic [PERIOD_WIDTH-1:0]                wait_o,
  output logic [shdrv_pkg::CoilWidth-1:0]        coil_o,
  output shdrv_pkg::result_t                     result_o
);

  logic                      move;
  logic                      up;
  logic [POSITION_WIDTH-1:0] pos_moved;
  logic [PERIOD_WIDTH-1:0]   period_eff;
  logic [63:0]               tgt_ext;

  assign pos_moved  = up ? pos_i + POSITION_WIDTH'(1) : pos_i - POSITION_WIDTH'(1);
  assign period_eff = (period_i == '0) ? PERIOD_WIDTH'(1) : period_i;
  assign tgt_ext    = {{(64 - shdrv_pkg::FieldWidth){target_step_i[shdrv_pkg::FieldWidth-1]}},
                       target_step_i};

  always_comb begin
    move   = 1'b0;
    up     = 1'b0;
    tgt_o  = tgt_i;
    wait_o = wait_i;
    case (op_i)
      shdrv_pkg::OP_TICK: begin
        if (wait_i == '0) begin
          wait_o = period_eff - PERIOD_WIDTH'(1);
          if ($signed(pos_i) < $signed(tgt_i)) begin
            move = 1'b1;
            up   = 1'b1;
          end else if ($signed(tgt_i) < $signed(pos_i)) begin
            move = 1'b1;
          end
        end else begin
          wait_o = wait_i - PERIOD_WIDTH'(1);
        end
      end
      shdrv_pkg::OP_SET_TGT: begin
        tgt_o = tgt_ext[POSITION_WIDTH-1:0];
      end
      shdrv_pkg::OP_STEP_CW: begin
        move = 1'b1;
        up   = 1'b1;
      end
      shdrv_pkg::OP_STEP_CCW: begin
        move = 1'b1;
      end
      default: begin
        move = 1'b0;
      end
    endcase
  end

  assign pos_o  = move ? pos_moved : pos_i;
  assign coil_o = move ? shdrv_pkg::half_step_coil(pos_moved[2:0]) : coil_i;

  assign result_o.coil_pattern = coil_o;
  assign result_o.position     = shdrv_pkg::FieldWidth'(pos_o);
  assign result_o.target       = shdrv_pkg::FieldWidth'(tgt_o);
  assign result_o.stepped      = move;

endmodule

>>> src/shdrv_checker.sv
// ----------------------------------------------------------------------------
// shdrv_checker
// Port-level assertions for the half-step position driver, bound to the top.
// ----------------------------------------------------------------------------
`include "stepper_half_step_position_driver_core_macros.svh"

module shdrv_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [shdrv_pkg::CoilWidth-1:0]     coil_pattern_o,
  input logic [shdrv_pkg::FieldWidth-1:0]    position_o,
  input logic [shdrv_pkg::FieldWidth-1:0]    target_o,
  input logic                                stepped_o
);

  // A step always leaves the coils on the table entry for the new position.
  `SHDRV_ASSERT_NOW(a_step_coil, clk_i, rst_ni, out_valid_o && stepped_o, coil_pattern_o == shdrv_pkg::half_step_coil(position_o[2:0]), "coil pattern does not match position")

  // Input back-pressure only when a result is already waiting.
  `SHDRV_ASSERT_NOW(a_ready_needs_full, clk_i, rst_ni, !in_ready_o, out_valid_o, "input stalled with empty output")

  // A stalled result holds.
  `SHDRV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(position_o) && $stable(target_o) && $stable(coil_pattern_o) && $stable(stepped_o), "stalled result changed")

endmodule

bind stepper_half_step_position_driver_core shdrv_checker u_shdrv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .coil_pattern_o (coil_pattern_o),
  .position_o     (position_o),
  .target_o       (target_o),
  .stepped_o      (stepped_o)
);

>>> tb/sv/stepper_half_step_position_driver_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepper_half_step_position_driver_core_tb
// Self-checking bench for the half-step position driver. A directed table
// first covers reset values, the target and period extremes, both manual
// step directions and wrap below zero. Random phases at several step
// periods then follow. Every result transaction is checked field by field
// against an in-bench model of the tick countdown, the position counter
// and the half-step coil table. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module stepper_half_step_position_driver_core_tb;

  localparam int unsigned DIR_ROWS    = 24;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 72;
  localparam int unsigned MAX_GAP     = 17;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned DRAIN_WAIT  = 5;
  localparam int unsigned CYCLE_LIMIT = 300000;

  // Half-step coil sequence, entry n at bits [4n+3:4n].
  localparam logic [31:0] COIL_SEQ = {4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8};

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [shdrv_pkg::CfgWidth-1:0]    cfg_wdata_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic [shdrv_pkg::OpWidth-1:0]     op_i;
  logic signed [31:0]                target_step_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic [shdrv_pkg::CoilWidth-1:0]   coil_pattern_o;
  logic signed [31:0]                position_o;
  logic signed [31:0]                target_o;
  logic                              stepped_o;

  stepper_half_step_position_driver_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .target_step_i  (target_step_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .coil_pattern_o (coil_pattern_o),
    .position_o     (position_o),
    .target_o       (target_o),
    .stepped_o      (stepped_o)
  );

  // --------------------------------------------------------------------------
  // Clock: 10 ns period
  // --------------------------------------------------------------------------
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Motion model state, mirrors the driver's registers
  // --------------------------------------------------------------------------
  logic signed [31:0] pos_q;
  logic signed [31:0] tgt_q;
  logic [15:0]        tick_wait_q;
  logic [3:0]         coil_q;
  logic [15:0]        period_q;

  shdrv_pkg::result_t pending_results[$];   // expected results, oldest first
  shdrv_pkg::result_t head_exp;
  int unsigned        mismatch_cnt;
  int unsigned        cycle_cnt;
  logic               quiet_mode;           // no idling on either side
  int unsigned        rx_hold_cycles;       // one-shot long stall request for the sink

  // Applies one transaction to the model and returns the result it yields.
  function automatic shdrv_pkg::result_t predict_motion(input shdrv_pkg::op_e op,
                                                        input logic [31:0] stim);
    shdrv_pkg::result_t r;
    logic               moved;
    moved = 1'b0;
    case (op)
      shdrv_pkg::OP_TICK: begin
        if (tick_wait_q == '0) begin
          // decision tick: one half step toward the target, if any
          if (pos_q < tgt_q) begin
            pos_q = pos_q + 1;
            moved = 1'b1;
          end else if (pos_q > tgt_q) begin
            pos_q = pos_q - 1;
            moved = 1'b1;
          end
          // period of zero behaves as one
          tick_wait_q = (period_q == '0) ? '0 : period_q - 16'd1;
        end else begin
          tick_wait_q = tick_wait_q - 16'd1;
        end
      end
      shdrv_pkg::OP_SET_TGT: tgt_q = stim;
      shdrv_pkg::OP_STEP_CW: begin
        pos_q = pos_q + 1;
        moved = 1'b1;
      end
      default: begin
        pos_q = pos_q - 1;
        moved = 1'b1;
      end
    endcase
    if (moved) coil_q = COIL_SEQ[{pos_q[2:0], 2'b00} +: 4];
    r.coil_pattern = coil_q;
    r.position     = pos_q;
    r.target       = tgt_q;
    r.stepped      = moved;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic               cfg_row;   // row writes step_period instead of sending
    logic [15:0]        period;
    shdrv_pkg::op_e     op;
    logic [31:0]        stim;
    logic               typed;     // expected result given in the row
    shdrv_pkg::result_t want;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS];

  function automatic dir_row_t item_row(input shdrv_pkg::op_e op, input logic [31:0] stim);
    dir_row_t r;
    r        = '0;
    r.op     = op;
    r.stim   = stim;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input shdrv_pkg::op_e op, input logic [31:0] stim,
                                         input logic [3:0] coil, input logic [31:0] pos,
                                         input logic [31:0] tgt, input logic moved);
    dir_row_t r;
    r                   = item_row(op, stim);
    r.typed             = 1'b1;
    r.want.coil_pattern = coil;
    r.want.position     = pos;
    r.want.target       = tgt;
    r.want.stepped      = moved;
    return r;
  endfunction

  function automatic dir_row_t period_row(input logic [15:0] p);
    dir_row_t r;
    r         = '0;
    r.cfg_row = 1'b1;
    r.period  = p;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------
  // Offers one transaction after a random gap, holds it until accepted, then
  // queues its expected result. Valid stays high on return; the next call or
  // the drain lowers it.
  task automatic send_item(input shdrv_pkg::op_e op, input logic [31:0] stim,
                           input logic typed, input shdrv_pkg::result_t want);
    int unsigned        gap;
    shdrv_pkg::result_t model_res;
    gap = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    target_step_i <= stim;
    do @(posedge clk_i); while (!in_ready_o);
    model_res = predict_motion(op, stim);
    pending_results.push_back(typed ? want : model_res);
  endtask

  // Stops offering, waits until every expected result has arrived, then
  // writes step_period while the block is idle.
  task automatic settle_and_set_period(input logic [15:0] p);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    period_q = p;
  endtask

  // --------------------------------------------------------------------------
  // Sink pacing: per-transaction random stall, or one long hold on request
  // --------------------------------------------------------------------------
  initial begin : sink_pacing
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles != 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
      end
      repeat (stall) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: position %0d", position_o);
        mismatch_cnt++;
      end else begin
        head_exp = pending_results.pop_front();
        if (coil_pattern_o !== head_exp.coil_pattern) begin
          $error("coil_pattern: expected %h, got %h", head_exp.coil_pattern, coil_pattern_o);
          mismatch_cnt++;
        end
        if (position_o !== head_exp.position) begin
          $error("position: expected %0d, got %0d", $signed(head_exp.position), position_o);
          mismatch_cnt++;
        end
        if (target_o !== head_exp.target) begin
          $error("target: expected %0d, got %0d", $signed(head_exp.target), target_o);
          mismatch_cnt++;
        end
        if (stepped_o !== head_exp.stepped) begin
          $error("stepped: expected %b, got %b", head_exp.stepped, stepped_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned    pick;
    logic [15:0]    per;
    logic [31:0]    stim;
    shdrv_pkg::op_e op;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    op_i           = shdrv_pkg::OP_TICK;
    target_step_i  = '0;
    mismatch_cnt   = 0;
    cycle_cnt      = 0;
    quiet_mode     = 1'b0;
    rx_hold_cycles = 0;

    // model reset state
    pos_q       = '0;
    tgt_q       = '0;
    tick_wait_q = '0;
    coil_q      = '0;
    period_q    = 16'(shdrv_pkg::PeriodReset);

    // Directed rows. Reset period is 10 and the first tick decides at once.
    // Rows with a typed result read straight off the reset state, the
    // target extremes and the coil table; the rest go through the model.
    dir_tab[0]  = typed_row(shdrv_pkg::OP_TICK,     32'hFFFF_FFFF,
                            4'h0, 32'h0,         32'h0,         1'b0);
    dir_tab[1]  = typed_row(shdrv_pkg::OP_SET_TGT,  32'h7FFF_FFFF,
                            4'h0, 32'h0,         32'h7FFF_FFFF, 1'b0);
    dir_tab[2]  = typed_row(shdrv_pkg::OP_STEP_CW,  32'hAAAA_AAAA,
                            4'hC, 32'h1,         32'h7FFF_FFFF, 1'b1);
    dir_tab[3]  = typed_row(shdrv_pkg::OP_STEP_CCW, 32'h5555_5555,
                            4'h8, 32'h0,         32'h7FFF_FFFF, 1'b1);
    // below zero: position wraps to all ones, coil entry 7
    dir_tab[4]  = typed_row(shdrv_pkg::OP_STEP_CCW, 32'h0,
                            4'h9, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    dir_tab[5]  = typed_row(shdrv_pkg::OP_SET_TGT,  32'h8000_0000,
                            4'h9, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    dir_tab[6]  = typed_row(shdrv_pkg::OP_SET_TGT,  32'hFFFF_FFFD,
                            4'h9, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 1'b0);
    // zero period acts as one; the pending countdown of nine runs out first
    dir_tab[7]  = period_row(16'h0000);
    for (int i = 8; i < 20; i++) dir_tab[i] = item_row(shdrv_pkg::OP_TICK, $urandom);
    // longest period, target above position: one step, then a long wait
    dir_tab[20] = period_row(16'hFFFF);
    dir_tab[21] = item_row(shdrv_pkg::OP_SET_TGT, 32'h0);
    dir_tab[22] = item_row(shdrv_pkg::OP_TICK, 32'h0);
    dir_tab[23] = item_row(shdrv_pkg::OP_TICK, 32'hFFFF_FFFF);

    // hold reset, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].cfg_row) begin
        settle_and_set_period(dir_tab[i].period);
      end else begin
        send_item(dir_tab[i].op, dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random phases. Each one starts with an idle period write, so the
    // source also pauses there until every result is back.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       per = 16'd1;
        1:       per = 16'($urandom_range(2, 6));
        2:       per = 16'd0;
        3:       per = 16'd3;
        4:       per = 16'hFFFF;
        default: per = 16'($urandom_range(1, 4));
      endcase
      settle_and_set_period(per);
      quiet_mode = (ph == 3);
      // long sink hold: both output entries fill and in_ready_o drops
      if (ph == 1) rx_hold_cycles = LONG_HOLD;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        stim = $urandom;
        if (pick < 50) begin
          op = shdrv_pkg::OP_TICK;
        end else if (pick < 70) begin
          op = shdrv_pkg::OP_SET_TGT;
          // mostly a target a few steps away so ticks keep moving the motor
          if ($urandom_range(0, 3) != 0) stim = pos_q + $urandom_range(0, 24) - 12;
        end else if (pick < 85) begin
          op = shdrv_pkg::OP_STEP_CW;
        end else begin
          op = shdrv_pkg::OP_STEP_CCW;
        end
        send_item(op, stim, 1'b0, '0);
      end
    end

    // drain, then give any stray result time to show up
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
